// File: sv/tgc_pkg.sv
// Shared types and constants for the touch gesture classifier.
`default_nettype none

package tgc_pkg;

   // Field widths
   localparam int COORD_BITS = 12;
   localparam int MOVE_BITS  = COORD_BITS + 1;
   localparam int MS_BITS    = 16;

   // Speed test arithmetic: (limit + 1) * dt against |delta| * 1000
   localparam int MULT_BITS  = MS_BITS + 1;
   localparam int MULT3_BITS = MULT_BITS + 2;
   localparam int PROD_BITS  = MS_BITS + MULT_BITS;
   localparam int MS_PER_S   = 1000;
   localparam int SPEED_BITS = COORD_BITS + 10;

   // Radix-4 serial multiplier: two bits of dt per cycle
   localparam int CALC_STEPS = MS_BITS / 2;
   localparam int CNT_BITS   = $clog2(CALC_STEPS + 1);

   // Configuration registers
   localparam int CSR_INDEX_BITS = 1;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LONG_CLICK_MS      = 1'b0,
      CSR_SCROLL_SPEED_LIMIT = 1'b1
   } csr_index_type;

   localparam logic [MS_BITS-1:0] LONG_CLICK_RESET   = MS_BITS'(500);
   localparam logic [MS_BITS-1:0] SCROLL_LIMIT_RESET = MS_BITS'(100);

   // Gesture tracking state
   typedef enum logic [1:0] {
      GS_NONE   = 2'd0,
      GS_CLICK  = 2'd1,
      GS_LONG   = 2'd2,
      GS_SCROLL = 2'd3
   } gesture_state_type;

   // Reported gesture codes
   localparam logic [1:0] GEST_CLICK  = 2'd0;
   localparam logic [1:0] GEST_LONG   = 2'd1;
   localparam logic [1:0] GEST_SCROLL = 2'd2;

   // Control sequencer
   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_CALC = 2'd1,
      FSM_HOLD = 2'd2
   } fsm_state_type;

   // Map an active tracking state to its reported code
   function automatic logic [1:0] gesture_code(input gesture_state_type st);
      logic [1:0] code;
      case (st)
         GS_CLICK:  code = GEST_CLICK;
         GS_LONG:   code = GEST_LONG;
         GS_SCROLL: code = GEST_SCROLL;
         default:   code = GEST_CLICK;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: sv/touch_gesture_classifier_unit.sv
// Top level of the touch gesture classifier: poll tracking and radix-4 serial speed test.
//
// One request transaction is one poll of a touch panel: pressed flag, x/y
// coordinates and the milliseconds since the previous poll. A poll yields
// zero or one response transaction: click, long click or scroll, with the
// last coordinates and the most recent per-poll movement. An ongoing scroll
// reports on every poll while held; any active gesture reports once on release.
// The csr channel writes long_click_ms (index 0) and scroll_speed_limit
// (index 1); csr_ready is always high, writes belong in idle periods.
// Timing: a poll is taken when req_ready is high, then runs through the calc
// states. The speed limit product (limit + 1) * dt is built by a radix-4
// shift-add unit that consumes two bits of the 16-bit elapsed time per cycle
// (8 steps), followed by a compare step. With the output register free, the
// response is valid on the cycle after that, and the next poll can then be taken.
// The response sits in an output register: a new poll is taken while it
// waits. If a second response is ready before the first one is taken, the
// block holds with req_ready low until rsp_ready frees the output register.
// Synchronous reset returns to idle with no gesture, clears the stored
// coordinates, movement and held time, and loads 500 ms and 100 px/s.
`default_nettype none

module touch_gesture_classifier_unit
   import tgc_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   // poll channel
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire                        req_pressed,
   input  wire  [COORD_BITS-1:0]      req_touch_x,
   input  wire  [COORD_BITS-1:0]      req_touch_y,
   input  wire  [MS_BITS-1:0]         req_elapsed_ms,
   // event channel
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [1:0]                 rsp_gesture,
   output logic                       rsp_released,
   output logic [COORD_BITS-1:0]      rsp_event_x,
   output logic [COORD_BITS-1:0]      rsp_event_y,
   output logic signed [MOVE_BITS-1:0] rsp_move_x,
   output logic signed [MOVE_BITS-1:0] rsp_move_y,
   // configuration channel
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [MS_BITS-1:0]         csr_wdata
);

   // Control
   fsm_state_type                fsm_ff, fsm_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;

   // Configuration
   logic [MS_BITS-1:0]           long_click_ff, long_click_in;
   logic [MS_BITS-1:0]           speed_limit_ff, speed_limit_in;

   // Gesture state
   gesture_state_type            gs_ff, gs_in;
   logic [COORD_BITS-1:0]        last_x_ff, last_x_in;
   logic [COORD_BITS-1:0]        last_y_ff, last_y_in;
   logic signed [MOVE_BITS-1:0]  delta_x_ff, delta_x_in;
   logic signed [MOVE_BITS-1:0]  delta_y_ff, delta_y_in;
   logic [MS_BITS-1:0]           held_ff, held_in;

   // Captured poll
   logic                         pressed_ff, pressed_in;
   logic [COORD_BITS-1:0]        x_ff, x_in;
   logic [COORD_BITS-1:0]        y_ff, y_in;

   // Serial multiplier
   logic [MS_BITS-1:0]           dt_sr_ff, dt_sr_in;
   logic [PROD_BITS-1:0]         acc_ff, acc_in;
   logic [MULT_BITS-1:0]         m1_ff, m1_in;
   logic [MULT3_BITS-1:0]        m3_ff, m3_in;
   logic [SPEED_BITS-1:0]        sx_ff, sx_in;
   logic [SPEED_BITS-1:0]        sy_ff, sy_in;

   // Pending event
   logic                         emit_ff, emit_in;
   logic [1:0]                   emit_code_ff, emit_code_in;
   logic                         emit_rel_ff, emit_rel_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_gesture_ff, rsp_gesture_in;
   logic                         rsp_released_ff, rsp_released_in;
   logic [COORD_BITS-1:0]        rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]        rsp_y_ff, rsp_y_in;
   logic signed [MOVE_BITS-1:0]  rsp_mx_ff, rsp_mx_in;
   logic signed [MOVE_BITS-1:0]  rsp_my_ff, rsp_my_in;

   logic accept;
   logic calc_last;
   logic out_free;
   logic load_rsp;

   assign accept    = req_valid && req_ready;
   assign calc_last = (fsm_ff == FSM_CALC) && (cnt_ff == CNT_BITS'(CALC_STEPS));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp  = (calc_last || (fsm_ff == FSM_HOLD)) && emit_ff && out_free;

   // Next state of the sequencer
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_IDLE: begin
            if (accept) fsm_in = FSM_CALC;
         end
         FSM_CALC: begin
            if (calc_last) begin
               if (emit_ff && !out_free) fsm_in = FSM_HOLD;
               else                      fsm_in = FSM_IDLE;
            end
         end
         FSM_HOLD: begin
            if (out_free) fsm_in = FSM_IDLE;
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   // Handshake and port outputs
   always_comb begin
      req_ready    = (fsm_ff == FSM_IDLE);
      csr_ready    = 1'b1;
      rsp_valid    = rsp_valid_ff;
      rsp_gesture  = rsp_gesture_ff;
      rsp_released = rsp_released_ff;
      rsp_event_x  = rsp_x_ff;
      rsp_event_y  = rsp_y_ff;
      rsp_move_x   = rsp_mx_ff;
      rsp_move_y   = rsp_my_ff;
   end

   // Configuration writes
   always_comb begin
      long_click_in  = long_click_ff;
      speed_limit_in = speed_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LONG_CLICK_MS:      long_click_in  = csr_wdata;
            CSR_SCROLL_SPEED_LIMIT: speed_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Datapath
   always_comb begin
      logic [MULT_BITS-1:0]   m1_new;
      logic [MULT3_BITS-1:0]  addend;
      logic [MS_BITS:0]       held_sum;
      logic [MS_BITS-1:0]     held_new;
      logic [COORD_BITS-1:0]  mag_x;
      logic [COORD_BITS-1:0]  mag_y;

      cnt_in       = cnt_ff;
      gs_in        = gs_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      delta_x_in   = delta_x_ff;
      delta_y_in   = delta_y_ff;
      held_in      = held_ff;
      pressed_in   = pressed_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dt_sr_in     = dt_sr_ff;
      acc_in       = acc_ff;
      m1_in        = m1_ff;
      m3_in        = m3_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      emit_in      = emit_ff;
      emit_code_in = emit_code_ff;
      emit_rel_in  = emit_rel_ff;

      m1_new   = MULT_BITS'(speed_limit_ff) + MULT_BITS'(1);
      held_sum = {1'b0, held_ff} + {1'b0, dt_sr_ff};
      held_new = held_sum[MS_BITS] ? {MS_BITS{1'b1}} : held_sum[MS_BITS-1:0];
      mag_x    = delta_x_ff[MOVE_BITS-1] ? COORD_BITS'(-delta_x_ff)
                                         : COORD_BITS'(delta_x_ff);
      mag_y    = delta_y_ff[MOVE_BITS-1] ? COORD_BITS'(-delta_y_ff)
                                         : COORD_BITS'(delta_y_ff);

      // Multiplier digit: two top bits of dt select 0, 1, 2 or 3 times m
      case (dt_sr_ff[MS_BITS-1 -: 2])
         2'd0:    addend = '0;
         2'd1:    addend = MULT3_BITS'(m1_ff);
         2'd2:    addend = MULT3_BITS'(m1_ff) << 1;
         2'd3:    addend = m3_ff;
         default: addend = '0;
      endcase

      // Capture the poll and load the multiplier
      if (accept) begin
         pressed_in = req_pressed;
         x_in       = req_touch_x;
         y_in       = req_touch_y;
         dt_sr_in   = (req_elapsed_ms == '0) ? MS_BITS'(1) : req_elapsed_ms;
         acc_in     = '0;
         m1_in      = m1_new;
         m3_in      = MULT3_BITS'(m1_new) + (MULT3_BITS'(m1_new) << 1);
         emit_in    = 1'b0;
         cnt_in     = '0;
      end

      if (fsm_ff == FSM_CALC) begin
         // Shift-add step, most significant digit first
         if (cnt_ff < CNT_BITS'(CALC_STEPS)) begin
            acc_in   = (acc_ff << 2) + PROD_BITS'(addend);
            dt_sr_in = dt_sr_ff << 2;
            cnt_in   = cnt_ff + CNT_BITS'(1);
         end

         // First cycle: track the touch and decide on an event
         if (cnt_ff == '0) begin
            if (pressed_ff) begin
               if (gs_ff == GS_NONE) begin
                  gs_in      = GS_CLICK;
                  delta_x_in = '0;
                  delta_y_in = '0;
                  held_new   = held_ff;
               end else begin
                  held_in    = held_new;
                  delta_x_in = $signed({1'b0, x_ff}) - $signed({1'b0, last_x_ff});
                  delta_y_in = $signed({1'b0, y_ff}) - $signed({1'b0, last_y_ff});
               end
               last_x_in = x_ff;
               last_y_in = y_ff;
               if (gs_ff == GS_SCROLL) begin
                  emit_in      = 1'b1;
                  emit_code_in = GEST_SCROLL;
                  emit_rel_in  = 1'b0;
               end else if (held_new >= long_click_ff) begin
                  gs_in = GS_LONG;
               end
            end else if (gs_ff != GS_NONE) begin
               emit_in      = 1'b1;
               emit_code_in = gesture_code(gs_ff);
               emit_rel_in  = 1'b1;
               gs_in        = GS_NONE;
               held_in      = '0;
            end
         end

         // Second cycle: |delta| * 1000 from the fresh deltas
         if (cnt_ff == CNT_BITS'(1)) begin
            sx_in = SPEED_BITS'(mag_x) * SPEED_BITS'(MS_PER_S);
            sy_in = SPEED_BITS'(mag_y) * SPEED_BITS'(MS_PER_S);
         end

         // Last cycle: a fast enough click turns into a scroll
         if (calc_last && (gs_ff == GS_CLICK)) begin
            if ((PROD_BITS'(sx_ff) >= acc_ff) || (PROD_BITS'(sy_ff) >= acc_ff)) begin
               gs_in = GS_SCROLL;
            end
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_gesture_in  = rsp_gesture_ff;
      rsp_released_in = rsp_released_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_mx_in       = rsp_mx_ff;
      rsp_my_in       = rsp_my_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_gesture_in  = emit_code_ff;
         rsp_released_in = emit_rel_ff;
         rsp_x_in        = last_x_ff;
         rsp_y_in        = last_y_ff;
         rsp_mx_in       = delta_x_ff;
         rsp_my_in       = delta_y_ff;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff         <= FSM_IDLE;
         cnt_ff         <= '0;
         long_click_ff  <= LONG_CLICK_RESET;
         speed_limit_ff <= SCROLL_LIMIT_RESET;
         gs_ff          <= GS_NONE;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         delta_x_ff     <= '0;
         delta_y_ff     <= '0;
         held_ff        <= '0;
         emit_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fsm_ff         <= fsm_in;
         cnt_ff         <= cnt_in;
         long_click_ff  <= long_click_in;
         speed_limit_ff <= speed_limit_in;
         gs_ff          <= gs_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         delta_x_ff     <= delta_x_in;
         delta_y_ff     <= delta_y_in;
         held_ff        <= held_in;
         emit_ff        <= emit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pressed_ff      <= pressed_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      dt_sr_ff        <= dt_sr_in;
      acc_ff          <= acc_in;
      m1_ff           <= m1_in;
      m3_ff           <= m3_in;
      sx_ff           <= sx_in;
      sy_ff           <= sy_in;
      emit_code_ff    <= emit_code_in;
      emit_rel_ff     <= emit_rel_in;
      rsp_gesture_ff  <= rsp_gesture_in;
      rsp_released_ff <= rsp_released_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_mx_ff       <= rsp_mx_in;
      rsp_my_ff       <= rsp_my_in;
   end

endmodule

`default_nettype wire

// File: sv/tgc_checker.sv
// Port-level checks for the touch gesture classifier, bound to the top level.
`default_nettype none

module tgc_checker
   import tgc_pkg::*;
(
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_ready,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire  [1:0]                  rsp_gesture,
   input wire                         rsp_released,
   input wire  [COORD_BITS-1:0]       rsp_event_x,
   input wire  [COORD_BITS-1:0]       rsp_event_y,
   input wire  signed [MOVE_BITS-1:0] rsp_move_x,
   input wire  signed [MOVE_BITS-1:0] rsp_move_y
);

   // A stalled event transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gesture)
         && $stable(rsp_released) && $stable(rsp_event_x) && $stable(rsp_event_y)
         && $stable(rsp_move_x) && $stable(rsp_move_y))
      else $error("event payload changed while stalled");

   // Only click, long click and scroll codes are reported
   a_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gesture == GEST_CLICK) || (rsp_gesture == GEST_LONG)
         || (rsp_gesture == GEST_SCROLL))
      else $error("illegal gesture code");

   // Events while still pressed come only from an ongoing scroll
   a_held_is_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_released |-> rsp_gesture == GEST_SCROLL)
      else $error("non-scroll event before release");

   // A poll runs through the calc states: no poll is taken right after another
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("poll accepted on consecutive cycles");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (.*);

`default_nettype wire

// File: verif/tb_touch_gesture_classifier_unit.sv
// Self-checking testbench for the touch gesture classifier: directed gestures, then random polls.
`timescale 1ns / 1ps

module tb_touch_gesture_classifier_unit
   import tgc_pkg::*;
();

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 25;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_POLLS  = 650;

   // One gesture report as seen on the rsp channel
   typedef struct packed {
      logic [1:0]            gesture;
      logic                  released;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [MOVE_BITS-1:0]  mx;
      logic [MOVE_BITS-1:0]  my;
   } gesture_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic                  req_pressed    = 1'b0;
   logic [COORD_BITS-1:0] req_touch_x    = '0;
   logic [COORD_BITS-1:0] req_touch_y    = '0;
   logic [MS_BITS-1:0]    req_elapsed_ms = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [1:0]                  rsp_gesture;
   logic                        rsp_released;
   logic [COORD_BITS-1:0]       rsp_event_x;
   logic [COORD_BITS-1:0]       rsp_event_y;
   logic signed [MOVE_BITS-1:0] rsp_move_x;
   logic signed [MOVE_BITS-1:0] rsp_move_y;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [MS_BITS-1:0]        csr_wdata = '0;

   // Tracker copy: thresholds and gesture state
   logic [MS_BITS-1:0]          cfg_long_ms;
   logic [MS_BITS-1:0]          cfg_speed;
   gesture_state_type           trk_state;
   logic [COORD_BITS-1:0]       trk_last_x;
   logic [COORD_BITS-1:0]       trk_last_y;
   logic signed [MOVE_BITS-1:0] trk_dx;
   logic signed [MOVE_BITS-1:0] trk_dy;
   logic [MS_BITS-1:0]          trk_held;

   gesture_report_type pending_reports[$];
   int fail_count     = 0;
   int polls_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   touch_gesture_classifier_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pressed    (req_pressed),
      .req_touch_x    (req_touch_x),
      .req_touch_y    (req_touch_y),
      .req_elapsed_ms (req_elapsed_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_gesture    (rsp_gesture),
      .rsp_released   (rsp_released),
      .rsp_event_x    (rsp_event_x),
      .rsp_event_y    (rsp_event_y),
      .rsp_move_x     (rsp_move_x),
      .rsp_move_y     (rsp_move_y),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // Tracker state after reset
   task automatic clear_tracker();
      cfg_long_ms = LONG_CLICK_RESET;
      cfg_speed   = SCROLL_LIMIT_RESET;
      trk_state   = GS_NONE;
      trk_last_x  = '0;
      trk_last_y  = '0;
      trk_dx      = '0;
      trk_dy      = '0;
      trk_held    = '0;
   endtask

   // Report built from the current tracker state
   function automatic gesture_report_type build_report(input logic released);
      gesture_report_type r;
      case (trk_state)
         GS_LONG:   r.gesture = GEST_LONG;
         GS_SCROLL: r.gesture = GEST_SCROLL;
         default:   r.gesture = GEST_CLICK;
      endcase
      r.released = released;
      r.x        = trk_last_x;
      r.y        = trk_last_y;
      r.mx       = trk_dx;
      r.my       = trk_dy;
      return r;
   endfunction

   // Advance the tracker by one accepted poll and queue any report it causes
   task automatic track_poll(input logic pressed, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y, input logic [MS_BITS-1:0] dt_in);
      logic [MS_BITS-1:0] dt;
      logic [MS_BITS:0]   held_sum;
      int                 ax;
      int                 ay;
      longint             limit;
      dt = (dt_in == '0) ? MS_BITS'(1) : dt_in;
      polls_sent++;
      if (pressed) begin
         if (trk_state == GS_NONE) begin
            // new touch: start as click, no movement yet
            trk_state = GS_CLICK;
            trk_dx    = '0;
            trk_dy    = '0;
         end else begin
            held_sum = {1'b0, trk_held} + {1'b0, dt};
            trk_held = held_sum[MS_BITS] ? '1 : held_sum[MS_BITS-1:0];
            trk_dx   = {1'b0, x} - {1'b0, trk_last_x};
            trk_dy   = {1'b0, y} - {1'b0, trk_last_y};
         end
         trk_last_x = x;
         trk_last_y = y;
         if (trk_state == GS_SCROLL) begin
            pending_reports.push_back(build_report(1'b0));
         end else if (trk_held >= cfg_long_ms) begin
            trk_state = GS_LONG;
         end
         // speed test runs after the scroll report, so entering scroll is silent
         if (trk_state == GS_CLICK) begin
            ax    = int'(trk_dx);
            ay    = int'(trk_dy);
            ax    = (ax < 0) ? -ax : ax;
            ay    = (ay < 0) ? -ay : ay;
            limit = (longint'(cfg_speed) + 1) * longint'(dt);
            if (longint'(ax) * MS_PER_S >= limit || longint'(ay) * MS_PER_S >= limit)
               trk_state = GS_SCROLL;
         end
      end else if (trk_state != GS_NONE) begin
         pending_reports.push_back(build_report(1'b1));
         trk_state = GS_NONE;
         trk_held  = '0;
      end
   endtask

   // Send one poll transaction; valid stays high afterwards until the next call or a drain
   task automatic send_poll(input logic pressed, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y, input logic [MS_BITS-1:0] dt);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_pressed    <= pressed;
      req_touch_x    <= x;
      req_touch_y    <= y;
      req_elapsed_ms <= dt;
      do @(posedge clock); while (!req_ready);
      track_poll(pressed, x, y, dt);
   endtask

   // Drop valid, wait for every queued report, then let the pipeline settle
   task automatic wait_quiet();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_reports.size() != 0) begin
         if (fail_count < REPORT_LIMIT)
            $display("missing %0d gesture reports", pending_reports.size());
         fail_count += pending_reports.size();
         pending_reports.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both thresholds while the block is quiet
   task automatic load_thresholds(input logic [MS_BITS-1:0] long_ms,
                                  input logic [MS_BITS-1:0] speed);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= CSR_LONG_CLICK_MS;
      csr_wdata <= long_ms;
      do @(posedge clock); while (!csr_ready);
      cfg_long_ms = long_ms;
      csr_index <= CSR_SCROLL_SPEED_LIMIT;
      csr_wdata <= speed;
      do @(posedge clock); while (!csr_ready);
      cfg_speed = speed;
      csr_valid <= 1'b0;
   endtask

   // Response checker and receiver stall pattern
   always @(posedge clock) begin : check_reports
      gesture_report_type want;
      gesture_report_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.gesture  = rsp_gesture;
         got.released = rsp_released;
         got.x        = rsp_event_x;
         got.y        = rsp_event_y;
         got.mx       = rsp_move_x;
         got.my       = rsp_move_y;
         if (pending_reports.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("unexpected report: gesture %0d released %0b", got.gesture,
                        got.released);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got !== want) begin
               if (fail_count < REPORT_LIMIT)
                  $display({"mismatch exp/act: gesture %0d/%0d released %0b/%0b ",
                            "x %0d/%0d y %0d/%0d mx %0d/%0d my %0d/%0d"},
                           want.gesture, got.gesture, want.released, got.released,
                           want.x, got.x, want.y, got.y,
                           $signed(want.mx), $signed(got.mx),
                           $signed(want.my), $signed(got.my));
               fail_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > 4095) return '1;
      return COORD_BITS'(v);
   endfunction

   // Mostly short poll intervals, sometimes zero, now and then any 16-bit value
   function automatic logic [MS_BITS-1:0] pick_dt();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 80) return MS_BITS'($urandom_range(40, 1));
      if (r < 95) return MS_BITS'($urandom_range(1000, 41));
      return MS_BITS'($urandom_range(65535));
   endfunction

   // One random touch: press, a few polls of motion, release; plus some broken sequences
   task automatic run_gesture();
      int r;
      int n;
      int style;
      int i;
      int x;
      int y;
      r = $urandom_range(99);
      if (r < 8) begin
         send_poll(1'b0, COORD_BITS'($urandom), COORD_BITS'($urandom), pick_dt());
      end else if (r < 15) begin
         send_poll(1'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom), pick_dt());
      end else begin
         n     = $urandom_range(12, 1);
         style = $urandom_range(3);
         x     = $urandom_range(4095);
         y     = $urandom_range(4095);
         for (i = 0; i < n; i++) begin
            send_poll(1'b1, clamp_coord(x), clamp_coord(y), pick_dt());
            case (style)
               0: ;
               1: begin
                  x = x + int'($urandom_range(4)) - 2;
                  y = y + int'($urandom_range(4)) - 2;
               end
               2: begin
                  x = x + int'($urandom_range(400)) - 200;
                  y = y + int'($urandom_range(400)) - 200;
               end
               default: begin
                  x = $urandom_range(4095);
                  y = $urandom_range(4095);
               end
            endcase
         end
         // occasionally leave the touch open
         if ($urandom_range(9) != 0)
            send_poll(1'b0, COORD_BITS'($urandom), COORD_BITS'($urandom), pick_dt());
      end
   endtask

   task automatic test_idle_release();
      send_poll(1'b0, '1, '1, '0);
   endtask

   task automatic test_short_click();
      send_poll(1'b1, '0, '0, '0);
      send_poll(1'b0, '1, '0, MS_BITS'(1));
   endtask

   // Held time saturation into a long click
   task automatic test_long_click();
      send_poll(1'b1, '1, '1, '1);
      send_poll(1'b1, '1, '1, '1);
      send_poll(1'b1, '1, '1, '1);
      send_poll(1'b0, '0, '0, '1);
   endtask

   // Entering scroll is silent, then each held poll reports, then release reports
   task automatic test_scroll();
      send_poll(1'b1, COORD_BITS'(100), COORD_BITS'(100), MS_BITS'(10));
      send_poll(1'b1, '1, '0, '0);
      send_poll(1'b1, '0, '1, MS_BITS'(5));
      send_poll(1'b0, COORD_BITS'(7), COORD_BITS'(9), MS_BITS'(3));
   endtask

   task automatic test_threshold_extremes();
      // zero long click time: first poll is already a long click
      load_thresholds('0, '0);
      send_poll(1'b1, COORD_BITS'(2048), COORD_BITS'(2048), MS_BITS'(1));
      send_poll(1'b0, '0, '0, MS_BITS'(1));
      // top speed limit: 65 px per ms is below, 66 is above
      load_thresholds('1, '1);
      send_poll(1'b1, COORD_BITS'(1000), COORD_BITS'(1000), MS_BITS'(1));
      send_poll(1'b1, COORD_BITS'(1065), COORD_BITS'(1000), MS_BITS'(1));
      send_poll(1'b1, COORD_BITS'(1065), COORD_BITS'(934), MS_BITS'(1));
      send_poll(1'b1, COORD_BITS'(1065), COORD_BITS'(934), MS_BITS'(1));
      send_poll(1'b0, '0, '0, MS_BITS'(1));
   endtask

   // Random touches in chunks, each chunk under its own thresholds
   task automatic test_random_polls(input int send_pct, input int recv_pct, input int budget);
      int chunk;
      int start;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (chunk = 0; chunk < 4; chunk++) begin
         case ($urandom_range(5))
            0: load_thresholds(MS_BITS'($urandom), MS_BITS'($urandom));
            1: load_thresholds($urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0);
            2: load_thresholds(LONG_CLICK_RESET, SCROLL_LIMIT_RESET);
            default: load_thresholds(MS_BITS'($urandom_range(1500, 100)),
                                     MS_BITS'($urandom_range(400)));
         endcase
         start = polls_sent;
         while (polls_sent - start < budget / 4) run_gesture();
      end
   endtask

   initial begin
      clear_tracker();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_release();
      test_short_click();
      test_long_click();
      test_scroll();
      test_threshold_extremes();

      test_random_polls(25, 49, RANDOM_POLLS / 3);
      test_random_polls(49, 25, RANDOM_POLLS / 3);
      test_random_polls(0, 0, RANDOM_POLLS / 3);

      wait_quiet();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
